[design/assert_macros.svh]
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_SAME(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("next-cycle check failed");

`endif

[design/cmmf_pkg.sv]
// Shared types and constants of the centered moving mean filter.
package cmmf_pkg;

	localparam int SAMPLE_BITS     = 32;
	localparam int MAX_WINDOW_DEF  = 64;
	localparam int CFG_DATA_BITS   = 7;
	localparam logic [CFG_DATA_BITS-1:0] WIDTH_RESET = 7'd8;

	typedef enum logic {
		CFG_WINDOW_WIDTH = 1'b0,
		CFG_FILTER_MODE  = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          sample_ok;
		logic                          record_end;
	} in_beat_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] value;
		logic                          value_ok;
		logic                          final_result;
	} out_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_DRAIN,
		ST_PREP,
		ST_DIV,
		ST_FIN,
		ST_ADV
	} state_t;

endpackage

[design/centered_moving_mean_filter_core.sv]
// Centered moving mean filter: line memory, window scan and bit-serial divider.
//
// Samples of a record enter one beat at a time and go into a line memory of
// MAX_WINDOW entries. Each accepted beat yields the result of the sample
// ceil(W/2)-1 beats back; the beat marked record_end also flushes every
// pending result, oldest first, and the next beat starts a new record. Each
// result rescans its clipped window from the line memory, one entry a cycle
// through the registered memory port, then a restoring divider forms the
// truncated mean one quotient bit a cycle over SAMPLE_BITS+clog2(MAX_WINDOW+1)
// bits, and the result then waits while the output register is stalled. The
// input is stalled from acceptance until the cycle after the last result of
// the beat is placed in the output register. The output register lets a
// result wait while the next beat is taken. Mode 0 returns the sample minus
// the mean of the finite window samples, mode 1 the plain window mean; value
// is 0 where value_ok is 0. Width values of 0 act as 1 and values above
// MAX_WINDOW act as MAX_WINDOW. Configuration must be written only while the
// block is idle; the block itself does not enforce this.
module centered_moving_mean_filter_core #(
	parameter int MAX_WINDOW = cmmf_pkg::MAX_WINDOW_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  cmmf_pkg::cfg_index_t                  cfg_index,
	input  logic [cmmf_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  cmmf_pkg::in_beat_t                    in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output cmmf_pkg::out_beat_t                   out_data
);

	localparam int SB   = cmmf_pkg::SAMPLE_BITS;
	localparam int AW   = $clog2(MAX_WINDOW);
	localparam int CW   = $clog2(MAX_WINDOW + 1);
	localparam int WW   = (CW > cmmf_pkg::CFG_DATA_BITS) ? CW : cmmf_pkg::CFG_DATA_BITS;
	localparam int SUMW = SB + CW;
	localparam int BW   = $clog2(SUMW + 1);

	// configuration
	logic [cmmf_pkg::CFG_DATA_BITS-1:0] width_q;
	logic                               mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= cmmf_pkg::WIDTH_RESET;
			mode_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cmmf_pkg::CFG_WINDOW_WIDTH: width_q <= cfg_data;
				cmmf_pkg::CFG_FILTER_MODE:  mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamp width, split into backward and forward reach
	logic [WW-1:0] w_wide;
	logic [CW-1:0] w_eff, lo_w, hi_w;

	always_comb begin
		w_wide = WW'(width_q);
		if (w_wide == '0)
			w_wide = WW'(1);
		else if (w_wide > WW'(MAX_WINDOW))
			w_wide = WW'(MAX_WINDOW);
		w_eff = w_wide[CW-1:0];
		lo_w  = w_eff >> 1;
		hi_w  = w_eff - lo_w;
	end

	// sequencer state
	cmmf_pkg::state_t state_q, state_d;

	logic [AW-1:0]   head_q, head_nxt;
	logic [CW-1:0]   seen_q;
	logic            end_q, first_q, final_q;
	logic [AW-1:0]   age_q, scan_q, oldest_q;
	logic            accept;
	logic            emit_now;
	logic            out_load;

	assign accept   = in_valid && !in_stall;
	assign emit_now = CW'(age_q) < seen_q;
	assign head_nxt = (head_q == AW'(MAX_WINDOW - 1)) ? '0 : head_q + AW'(1);
	assign out_load = (state_q == cmmf_pkg::ST_FIN) && (!out_valid || !out_stall);

	logic [BW-1:0] bit_q;

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			cmmf_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid)
					state_d = cmmf_pkg::ST_CHECK;
			end
			cmmf_pkg::ST_CHECK: state_d = emit_now ? cmmf_pkg::ST_SCAN : cmmf_pkg::ST_ADV;
			cmmf_pkg::ST_SCAN: begin
				if (scan_q == oldest_q)
					state_d = cmmf_pkg::ST_DRAIN;
			end
			cmmf_pkg::ST_DRAIN: state_d = cmmf_pkg::ST_PREP;
			cmmf_pkg::ST_PREP:  state_d = cmmf_pkg::ST_DIV;
			cmmf_pkg::ST_DIV: begin
				if (bit_q == BW'(1))
					state_d = cmmf_pkg::ST_FIN;
			end
			cmmf_pkg::ST_FIN: begin
				if (out_load)
					state_d = cmmf_pkg::ST_ADV;
			end
			cmmf_pkg::ST_ADV: begin
				if (!end_q || age_q == '0)
					state_d = cmmf_pkg::ST_IDLE;
				else
					state_d = cmmf_pkg::ST_CHECK;
			end
			default: state_d = cmmf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= cmmf_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// window bounds of the result about to be formed
	logic [CW:0] reach;
	logic [CW-1:0] seen_m1;
	logic [AW-1:0] oldest_d;

	always_comb begin
		reach    = {1'b0, CW'(age_q)} + {1'b0, lo_w};
		seen_m1  = seen_q - CW'(1);
		oldest_d = (reach > {1'b0, seen_m1}) ? seen_m1[AW-1:0] : reach[AW-1:0];
	end

	// control registers: advance the line head, walk the pending ages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			seen_q   <= '0;
			end_q    <= 1'b0;
			first_q  <= 1'b0;
			final_q  <= 1'b0;
			age_q    <= '0;
			scan_q   <= '0;
			oldest_q <= '0;
		end else begin
			unique case (state_q)
				cmmf_pkg::ST_IDLE: begin
					if (accept) begin
						head_q  <= head_nxt;
						if (seen_q != CW'(MAX_WINDOW))
							seen_q <= seen_q + CW'(1);
						end_q   <= in_data.record_end;
						age_q   <= AW'(hi_w - CW'(1));
						first_q <= 1'b1;
					end
				end
				cmmf_pkg::ST_CHECK: begin
					scan_q   <= '0;
					oldest_q <= oldest_d;
					final_q  <= first_q ? (end_q && hi_w == CW'(1)) : (age_q == '0);
				end
				cmmf_pkg::ST_SCAN: begin
					if (scan_q != oldest_q)
						scan_q <= scan_q + AW'(1);
				end
				cmmf_pkg::ST_ADV: begin
					if (end_q) begin
						if (age_q == '0) begin
							seen_q <= '0;
						end else begin
							age_q   <= age_q - AW'(1);
							first_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// line memory: one write port, one registered read port
	logic [SB:0]   line_mem [MAX_WINDOW];
	logic [AW:0]   rd_slot;
	logic [AW-1:0] rd_addr;
	logic [SB:0]   rd_data_s1;
	logic [AW-1:0] rd_age_s1;
	logic          rd_v_s1;

	always_comb begin
		if (head_q >= scan_q)
			rd_slot = {1'b0, head_q} - {1'b0, scan_q};
		else
			rd_slot = {1'b0, head_q} + (AW+1)'(MAX_WINDOW) - {1'b0, scan_q};
		rd_addr = rd_slot[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept)
			line_mem[head_nxt] <= {in_data.sample_ok, in_data.sample};
		rd_data_s1 <= line_mem[rd_addr];
		rd_age_s1  <= scan_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_v_s1 <= 1'b0;
		else
			rd_v_s1 <= (state_q == cmmf_pkg::ST_SCAN);
	end

	// window totals, center sample
	logic signed [SUMW-1:0] sum_q;
	logic [CW-1:0]          fin_cnt_q, bad_cnt_q;
	logic [SB:0]            center_q;

	always_ff @(posedge clk) begin
		if (state_q == cmmf_pkg::ST_CHECK) begin
			sum_q     <= '0;
			fin_cnt_q <= '0;
			bad_cnt_q <= '0;
		end else if (rd_v_s1) begin
			if (rd_data_s1[SB]) begin
				sum_q     <= sum_q + SUMW'(signed'(rd_data_s1[SB-1:0]));
				fin_cnt_q <= fin_cnt_q + CW'(1);
			end else begin
				bad_cnt_q <= bad_cnt_q + CW'(1);
			end
			if (rd_age_s1 == age_q)
				center_q <= rd_data_s1;
		end
	end

	// restoring divider, one quotient bit a cycle into the dividend register
	logic [SUMW-1:0] dvd_q;
	logic [CW-1:0]   div_q, rem_q;
	logic            neg_q, ok_q;
	logic [CW:0]     trial, trial_diff;
	logic            q_bit;

	always_comb begin
		trial      = {rem_q, dvd_q[SUMW-1]};
		trial_diff = trial - {1'b0, div_q};
		q_bit      = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk) begin
		if (state_q == cmmf_pkg::ST_PREP) begin
			div_q <= mode_q ? fin_cnt_q + bad_cnt_q : fin_cnt_q;
			ok_q  <= mode_q ? (bad_cnt_q == '0 && fin_cnt_q != '0)
			                : (center_q[SB] && fin_cnt_q != '0);
			neg_q <= sum_q[SUMW-1];
			dvd_q <= sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
			rem_q <= '0;
			bit_q <= BW'(SUMW);
		end else if (state_q == cmmf_pkg::ST_DIV) begin
			rem_q <= q_bit ? trial_diff[CW-1:0] : trial[CW-1:0];
			dvd_q <= {dvd_q[SUMW-2:0], q_bit};
			bit_q <= bit_q - BW'(1);
		end
	end

	// signed mean, difference and saturation
	logic [SB:0]          q_mag;
	logic signed [SB:0]   q_signed;
	logic signed [SB+1:0] diff;
	logic [SB-1:0]        sat_val;

	always_comb begin
		q_mag    = dvd_q[SB:0];
		q_signed = neg_q ? -signed'(q_mag) : signed'(q_mag);
		if (mode_q)
			diff = (SB+2)'(q_signed);
		else
			diff = (SB+2)'(signed'(center_q[SB-1:0])) - (SB+2)'(q_signed);
		if (diff[SB+1:SB-1] == '0 || diff[SB+1:SB-1] == '1)
			sat_val = diff[SB-1:0];
		else if (diff[SB+1])
			sat_val = {1'b1, {(SB-1){1'b0}}};
		else
			sat_val = {1'b0, {(SB-1){1'b1}}};
	end

	// output register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (out_load)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data.value        <= ok_q ? signed'(sat_val) : '0;
			out_data.value_ok     <= ok_q;
			out_data.final_result <= final_q;
		end
	end

endmodule

[design/cmmf_checker.sv]
// Port-level checker for the centered moving mean filter, with its bind.
`include "assert_macros.svh"

module cmmf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input cmmf_pkg::out_beat_t out_data
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(out_data))
	`ASSERT_SAME(a_bad_is_zero, clk, arst_n, out_valid && !out_data.value_ok, out_data.value == '0)
	`ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_valid && !in_stall, in_stall)

endmodule

bind centered_moving_mean_filter_core cmmf_checker u_cmmf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

[bench/tb_top.sv]
// Self-checking testbench for the centered moving mean filter core.
`timescale 1ns / 1ps

module tb_top;

	localparam int LINE_DEPTH = cmmf_pkg::MAX_WINDOW_DEF;
	localparam int SAMPLE_BITS = cmmf_pkg::SAMPLE_BITS;
	localparam int CFG_DATA_BITS = cmmf_pkg::CFG_DATA_BITS;
	localparam int SETTLE_CYCLES = 300;
	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic clk;
	logic arst_n;
	logic cfg_we;
	cmmf_pkg::cfg_index_t cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	cmmf_pkg::in_beat_t in_data;
	logic out_valid;
	logic out_stall;
	cmmf_pkg::out_beat_t out_data;

	centered_moving_mean_filter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Predictor state: sample history ring, record fill and the live settings.
	logic [SAMPLE_BITS:0] hist_ring [LINE_DEPTH];
	int unsigned hist_head;
	int unsigned hist_fill;
	logic [CFG_DATA_BITS-1:0] width_reg;
	logic mode_reg;

	cmmf_pkg::in_beat_t pending_beats[$];
	cmmf_pkg::out_beat_t expected_results[$];
	int mismatches;
	int gap_left;
	int stall_left;
	bit no_idle;

	// Pick an idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (no_idle || r < 60)
			return 0;
		if (r < 94)
			return $urandom_range(3, 1);
		return $urandom_range(60, 15);
	endfunction

	function automatic logic [SAMPLE_BITS:0] hist_at(int unsigned age);
		return hist_ring[(hist_head + LINE_DEPTH - (age % LINE_DEPTH)) % LINE_DEPTH];
	endfunction

	// Compute the filtered result centered on the sample at the given age.
	function automatic cmmf_pkg::out_beat_t mean_result(int unsigned age, int unsigned lo,
			int unsigned hi, bit last);
		int unsigned first_age;
		int unsigned oldest_age;
		longint acc;
		int unsigned n_ok;
		int unsigned n_bad;
		logic [SAMPLE_BITS:0] e;
		logic [SAMPLE_BITS:0] center;
		longint v;
		bit good;
		cmmf_pkg::out_beat_t r;
		first_age = (age + 1 >= hi) ? age + 1 - hi : 0;
		oldest_age = age + lo;
		if (oldest_age >= hist_fill)
			oldest_age = hist_fill - 1;
		acc = 0;
		n_ok = 0;
		n_bad = 0;
		for (int unsigned a = first_age; a <= oldest_age; a++) begin
			e = hist_at(a);
			if (e[SAMPLE_BITS]) begin
				acc += longint'($signed(e[SAMPLE_BITS-1:0]));
				n_ok++;
			end else begin
				n_bad++;
			end
		end
		center = hist_at(age);
		v = 0;
		if (!mode_reg) begin
			good = center[SAMPLE_BITS] && n_ok > 0;
			if (good)
				v = longint'($signed(center[SAMPLE_BITS-1:0])) - acc / longint'(n_ok);
		end else begin
			good = n_bad == 0 && n_ok > 0;
			if (good)
				v = acc / longint'(n_ok);
		end
		// Clamp to the sample range.
		if (v > longint'(S_MAX))
			v = longint'(S_MAX);
		if (v < longint'(S_MIN))
			v = longint'(S_MIN);
		r.value = v[SAMPLE_BITS-1:0];
		r.value_ok = good;
		r.final_result = last;
		return r;
	endfunction

	// Append one expected result to the scoreboard.
	task automatic add_expected(cmmf_pkg::out_beat_t r);
		expected_results = {expected_results, r};
	endtask

	// Advance the history by one accepted beat and queue the results it releases.
	task automatic predict_beat(cmmf_pkg::in_beat_t b);
		int unsigned w;
		int unsigned lo;
		int unsigned hi;
		int unsigned a;
		w = width_reg;
		if (w < 1)
			w = 1;
		if (w > LINE_DEPTH)
			w = LINE_DEPTH;
		lo = w / 2;
		hi = w - lo;
		hist_head = (hist_head + 1) % LINE_DEPTH;
		hist_ring[hist_head] = {b.sample_ok, b.sample};
		if (hist_fill < LINE_DEPTH)
			hist_fill++;
		if (hi - 1 < hist_fill)
			add_expected(mean_result(hi - 1, lo, hi, b.record_end && hi == 1));
		if (b.record_end) begin
			// Flush the pending tail of the record, oldest first.
			a = hi - 1;
			while (a > 0) begin
				a--;
				if (a < hist_fill)
					add_expected(mean_result(a, lo, hi, a == 0));
			end
			hist_fill = 0;
		end
	endtask

	// Driver: predict each accepted beat, then present the next one after its gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall)
				predict_beat(in_data);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					in_data <= pending_beats.pop_front();
					in_valid <= 1'b1;
					gap_left = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result value=%0d ok=%0b last=%0b",
							out_data.value, out_data.value_ok, out_data.final_result);
				end else if (out_data !== expected_results[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
							expected_results[0].value, expected_results[0].value_ok,
							expected_results[0].final_result, out_data.value,
							out_data.value_ok, out_data.final_result);
					void'(expected_results.pop_front());
				end else begin
					void'(expected_results.pop_front());
				end
			end
			// Hold off the result stream in bursts.
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				stall_left = pick_gap();
				out_stall <= stall_left > 0;
			end
		end
	end

	// Wait until every beat went in and every result came out, then let it settle.
	task automatic drain();
		do
			@(posedge clk);
		while (pending_beats.size() > 0 || in_valid || expected_results.size() > 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cmmf_pkg::cfg_index_t idx, logic [CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == cmmf_pkg::CFG_WINDOW_WIDTH)
			width_reg = val;
		else
			mode_reg = val[0];
	endtask

	task automatic put_beat(logic signed [SAMPLE_BITS-1:0] s, logic ok, logic last);
		cmmf_pkg::in_beat_t b;
		b.sample = s;
		b.sample_ok = ok;
		b.record_end = last;
		pending_beats = {pending_beats, b};
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(9))
			0: return S_MAX;
			1: return S_MIN;
			2: return $urandom_range(3) - 2;
			3, 4: return $signed($urandom_range(2000)) - 1000;
			default: return $urandom;
		endcase
	endfunction

	// Queue one record of random content; most samples finite.
	task automatic put_record(int len, int bad_pct);
		for (int i = 0; i < len; i++)
			put_beat(rand_sample(), $urandom_range(99) >= bad_pct, i == len - 1);
	endtask

	initial begin
		int sent;
		int len;
		int r;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = cmmf_pkg::CFG_WINDOW_WIDTH;
		cfg_data = '0;
		mismatches = 0;
		gap_left = 0;
		stall_left = 0;
		no_idle = 1'b0;
		hist_head = 0;
		hist_fill = 0;
		width_reg = cmmf_pkg::WIDTH_RESET;
		mode_reg = 1'b0;
		for (int i = 0; i < LINE_DEPTH; i++)
			hist_ring[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: short record at full-scale extremes.
		put_beat(S_MAX, 1'b1, 1'b0);
		put_beat(S_MIN, 1'b1, 1'b0);
		put_beat(32'sd0, 1'b1, 1'b1);
		drain();

		// Narrow window, mode 0: saturating differences, non-finite center,
		// then a record with no finite sample at all.
		write_reg(cmmf_pkg::CFG_WINDOW_WIDTH, 7'd2);
		put_beat(S_MAX, 1'b1, 1'b0);
		put_beat(S_MIN, 1'b1, 1'b0);
		put_beat(S_MIN, 1'b1, 1'b0);
		put_beat(S_MAX, 1'b1, 1'b1);
		put_beat(32'sd5, 1'b0, 1'b0);
		put_beat(-32'sd7, 1'b1, 1'b0);
		put_beat(-32'sd3, 1'b0, 1'b1);
		put_beat(32'sd9, 1'b0, 1'b0);
		put_beat(32'sd1, 1'b0, 1'b1);
		drain();

		// Width 0 acts as 1; mode 1 with a non-finite sample.
		write_reg(cmmf_pkg::CFG_WINDOW_WIDTH, 7'd0);
		write_reg(cmmf_pkg::CFG_FILTER_MODE, 7'd1);
		put_beat(S_MAX, 1'b1, 1'b0);
		put_beat(S_MIN, 1'b0, 1'b0);
		put_beat(-32'sd7, 1'b1, 1'b1);
		drain();

		// Width above the line depth clamps; record shorter than the window.
		write_reg(cmmf_pkg::CFG_WINDOW_WIDTH, 7'd127);
		put_record(5, 0);
		put_beat(-32'sd1, 1'b1, 1'b1);
		drain();

		// Width changed in the middle of a record.
		write_reg(cmmf_pkg::CFG_WINDOW_WIDTH, 7'd5);
		write_reg(cmmf_pkg::CFG_FILTER_MODE, 7'd0);
		put_beat(32'sd100, 1'b1, 1'b0);
		put_beat(-32'sd50, 1'b1, 1'b0);
		drain();
		write_reg(cmmf_pkg::CFG_WINDOW_WIDTH, 7'd3);
		put_record(4, 10);
		drain();

		// Random phases: new settings between records, mostly narrow windows.
		sent = 0;
		while (sent < 500) begin
			r = $urandom_range(9);
			if (r == 0)
				write_reg(cmmf_pkg::CFG_WINDOW_WIDTH, 7'd64);
			else if (r == 1)
				write_reg(cmmf_pkg::CFG_WINDOW_WIDTH, 7'd1);
			else
				write_reg(cmmf_pkg::CFG_WINDOW_WIDTH,
					CFG_DATA_BITS'($urandom_range(16, 1)));
			write_reg(cmmf_pkg::CFG_FILTER_MODE, CFG_DATA_BITS'($urandom_range(1)));
			no_idle = $urandom_range(3) == 0;
			for (int k = 0; k < 3; k++) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(90, 40) : $urandom_range(20, 1);
				put_record(len, $urandom_range(2) == 0 ? 40 : 5);
				sent += len;
			end
			drain();
		end

		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#100ms;
		$display("tb_top: errors");
		$finish;
	end

endmodule
